>>> hdl/sawarq_pkg.sv
// Shared types and constants for the stop-and-wait ARQ sender.
package sawarq_pkg;

  // Ring depth default and the fixed width of the slot field on the result
  localparam int unsigned TX_SLOTS_DEF = 8;
  localparam int unsigned SLOT_W       = 3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd3;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_SERVICE = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_NOP     = 2'd3
  } act_e;

  // Input tdata fields; last member sits in the lowest bits
  typedef struct packed {
    logic       rx_is_ack;
    logic [7:0] rx_sequence;
    logic       rx_valid;
    logic       channel_busy;
    logic [7:0] frame_sequence;
    logic       frame_is_broadcast;
    logic       frame_is_datagram;
    logic       frame_is_ack;
  } in_data_t;

  typedef struct packed {
    act_e     action;
    in_data_t data;
  } in_item_t;

  // Result tdata fields; last member sits in the lowest bits
  typedef struct packed {
    logic              queue_empty;
    logic [7:0]        error_count;
    logic              enqueue_rejected;
    logic              rx_delivered;
    logic              ack_matched;
    logic              failure;
    logic              full_power;
    logic              tx_waits_ack;
    logic [7:0]        tx_sequence;
    logic [SLOT_W-1:0] tx_slot;
    logic              transmit;
  } result_t;

  localparam int unsigned IN_W        = $bits(in_data_t);
  localparam int unsigned RES_W       = $bits(result_t);
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned TUSER_W     = $bits(act_e);

endpackage

>>> hdl/sawarq_in_reg.sv
// Input register stage: holds one accepted beat until the core consumes it.
module sawarq_in_reg
  import sawarq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/sawarq_core.sv
// Sender state and the single-pass step logic for one item.
module sawarq_core
  import sawarq_pkg::*;
#(
  parameter int unsigned TX_SLOTS = TX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  in_item_t              item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output result_t               result_o
);

  localparam int unsigned IDX_W = $clog2(TX_SLOTS);
  localparam logic [TX_SLOTS-1:0] ONE = {{(TX_SLOTS-1){1'b0}}, 1'b1};

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    if (i == IDX_W'(TX_SLOTS - 1)) begin
      n = '0;
    end else begin
      n = i + IDX_W'(1);
    end
    return n;
  endfunction

  // Configuration
  logic [7:0]  retry_limit_q;
  logic [15:0] timeout_ticks_q;

  // Control state
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [TX_SLOTS-1:0] await_q, await_d;
  logic [7:0]          next_seq_q, next_seq_d;
  logic [7:0]          retry_q, retry_d;
  logic                resend_q, resend_d;
  logic [15:0]         timer_q, timer_d;
  logic [7:0]          fail_q, fail_d;

  // Slot store, no reset
  logic [7:0] seq_mem    [TX_SLOTS];
  logic       isack_mem  [TX_SLOTS];
  logic       nowait_mem [TX_SLOTS];

  in_data_t d;
  assign d = item_i.data;

  // Service pass, first phase: decide on the tail frame
  logic empty_q, full_q;
  logic serve_fresh, timed_out, retry_ok, schedule, drop;
  logic [IDX_W-1:0]    tail_a, tail_b, tail_c;
  logic [TX_SLOTS-1:0] await_a, await_b, await_c;
  logic resend_a, empty_a;

  assign empty_q     = head_q == tail_q;
  assign full_q      = ring_next(head_q) == tail_q;
  assign serve_fresh = !empty_q && !await_q[tail_q];
  assign timed_out   = !empty_q && await_q[tail_q] && (timer_q == '0);
  assign retry_ok    = retry_q < retry_limit_q;
  assign schedule    = timed_out && retry_ok;
  assign drop        = timed_out && !retry_ok;
  assign tail_a      = drop ? ring_next(tail_q) : tail_q;
  assign await_a     = drop ? (await_q & ~(ONE << tail_q)) : await_q;
  assign resend_a    = serve_fresh ? 1'b0 : (schedule ? 1'b1 : resend_q);
  assign empty_a     = head_q == tail_a;

  // Second phase: send the (possibly new) tail frame
  logic       do_send, s_is_ack, s_no_wait, send_waits;
  logic [7:0] seq_tx, seq_cur;

  assign do_send    = (serve_fresh || resend_a) && !empty_a && !d.channel_busy;
  assign s_is_ack   = isack_mem[tail_a];
  assign s_no_wait  = nowait_mem[tail_a];
  assign seq_tx     = s_is_ack ? seq_mem[tail_a] : next_seq_q;
  assign send_waits = !(s_no_wait || s_is_ack);
  assign tail_b     = (do_send && !send_waits) ? ring_next(tail_a) : tail_a;
  assign await_b    = (do_send && send_waits) ? (await_a | (ONE << tail_a)) : await_a;

  // Third phase: received ack. Only the tail slot can wait, so a waiting
  // tail_b is tail_a and its sequence is seq_cur.
  logic ack_hit;
  assign seq_cur = do_send ? seq_tx : seq_mem[tail_a];
  assign ack_hit = d.rx_valid && await_b[tail_b] && (seq_cur == d.rx_sequence) &&
                   d.rx_is_ack;
  assign tail_c  = ack_hit ? ring_next(tail_b) : tail_b;
  assign await_c = ack_hit ? (await_b & ~(ONE << tail_b)) : await_b;

  // Slot write port
  logic             slot_we, slot_we_meta;
  logic [IDX_W-1:0] slot_addr;
  logic [7:0]       slot_seq_wr;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    await_d      = await_q;
    next_seq_d   = next_seq_q;
    retry_d      = retry_q;
    resend_d     = resend_q;
    timer_d      = timer_q;
    fail_d       = fail_q;
    slot_we      = 1'b0;
    slot_we_meta = 1'b0;
    slot_addr    = head_q;
    slot_seq_wr  = d.frame_sequence;
    result_o     = '0;

    case (item_i.action)
      ACT_ENQUEUE: begin
        if (full_q) begin
          result_o.enqueue_rejected = 1'b1;
        end else begin
          await_d      = await_q & ~(ONE << head_q);
          slot_we      = 1'b1;
          slot_we_meta = 1'b1;
          head_d       = ring_next(head_q);
        end
      end
      ACT_SERVICE: begin
        tail_d   = tail_c;
        await_d  = await_c;
        resend_d = do_send ? 1'b0 : resend_a;
        if (serve_fresh) begin
          retry_d = '0;
        end else if (schedule) begin
          retry_d = retry_q + 8'd1;
        end
        if (drop && (fail_q != 8'hFF)) begin
          fail_d = fail_q + 8'd1;
        end
        if (d.rx_valid) begin
          fail_d = '0;
        end
        if (do_send) begin
          if (send_waits) begin
            timer_d = timeout_ticks_q;
          end
          if (!s_is_ack) begin
            next_seq_d  = next_seq_q + 8'd1;
            slot_we     = 1'b1;
            slot_addr   = tail_a;
            slot_seq_wr = next_seq_q;
          end
        end
        result_o.transmit     = do_send;
        result_o.tx_slot      = do_send ? SLOT_W'(tail_a) : '0;
        result_o.tx_sequence  = do_send ? seq_tx : '0;
        result_o.tx_waits_ack = do_send && send_waits;
        result_o.full_power   = schedule;
        result_o.failure      = drop;
        result_o.ack_matched  = ack_hit;
        result_o.rx_delivered = d.rx_valid;
      end
      ACT_TICK: begin
        if (timer_q != '0) begin
          timer_d = timer_q - 16'd1;
        end
      end
      default: ;
    endcase

    result_o.error_count = fail_d;
    result_o.queue_empty = head_d == tail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      await_q    <= '0;
      next_seq_q <= '0;
      retry_q    <= '0;
      resend_q   <= 1'b0;
      timer_q    <= '0;
      fail_q     <= '0;
    end else if (step_i) begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      await_q    <= await_d;
      next_seq_q <= next_seq_d;
      retry_q    <= retry_d;
      resend_q   <= resend_d;
      timer_q    <= timer_d;
      fail_q     <= fail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q   <= RETRY_LIMIT_RST;
      timeout_ticks_q <= TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RETRY_LIMIT:   retry_limit_q   <= cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && slot_we) begin
      seq_mem[slot_addr] <= slot_seq_wr;
    end
    if (step_i && slot_we_meta) begin
      isack_mem[slot_addr]  <= d.frame_is_ack;
      nowait_mem[slot_addr] <= d.frame_is_datagram || d.frame_is_broadcast;
    end
  end

endmodule

>>> hdl/sawarq_out_reg.sv
// Result register: holds one result beat until the downstream side takes it.
module sawarq_out_reg
  import sawarq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hdl/stop_and_wait_arq_sender.sv
// Top level of the stop-and-wait ARQ sender.
//
// Usage: every input beat on the s_axis side is one command, selected by
// tuser: enqueue a frame into the transmit ring, run a service pass (send the
// tail frame if the channel is clear, handle timeouts, retries and a received
// ack), or count one timer tick. Every input beat yields exactly one result
// beat on the m_axis side, in order, telling what was sent, whether a retry
// was scheduled or a frame dropped, whether an ack matched, plus the error
// count and the ring-empty flag.
// Flow: an accepted beat is held in the input register; when the result
// register is free, the step logic updates the sender state and loads the
// result register at the same edge, and the result is then shown on m_axis.
// Throughput: one beat per cycle while m_axis_tready is high; the state update
// is a single pass of compares and small increments between those registers.
// Stall: when m_axis_tready is low the result register holds, the input
// register fills, and s_axis_tready drops until the result is taken.
// Reset: ring empty, no frame waiting, counters and timer zero; retry limit
// 3, timeout 500 ticks. Config writes (cfg_we_i) are taken at any edge and
// must only be issued while no beat is in flight.
module stop_and_wait_arq_sender
  import sawarq_pkg::*;
#(
  parameter int unsigned TX_SLOTS = TX_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command beats
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // frame_is_ack, frame_is_datagram, frame_is_broadcast, frame_sequence[7:0],
  // channel_busy, rx_valid, rx_sequence[7:0], rx_is_ack, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [TUSER_W-1:0]     s_axis_tuser,
  // Result beats
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // transmit, tx_slot[2:0], tx_sequence[7:0], tx_waits_ack, full_power,
  // failure, ack_matched, rx_delivered, enqueue_rejected, error_count[7:0],
  // queue_empty, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  in_item_t in_item, held_item;
  logic     held_valid;
  logic     out_free;
  logic     advance;     // held beat moves through the step logic this cycle
  result_t  step_res, out_res;

  assign in_item.action = act_e'(s_axis_tuser);
  assign in_item.data   = in_data_t'(s_axis_tdata[IN_W-1:0]);

  sawarq_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  assign advance = held_valid && out_free;

  sawarq_core #(
    .TX_SLOTS (TX_SLOTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (held_item),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (step_res)
  );

  sawarq_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (step_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_res);

endmodule

>>> hdl/sawarq_checker.sv
// Port-level checks for the ARQ sender, bound to the top level.
module sawarq_port_checks
  import sawarq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  result_t res;
  assign res = result_t'(m_axis_tdata[RES_W-1:0]);

  // A stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Input side only backs up behind a pending result
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("s_axis_tready low with no result pending");

  // A matched ack is a delivered reception, which clears the error count
  a_ack_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.ack_matched |-> res.rx_delivered && (res.error_count == 8'd0))
    else $error("ack matched without delivery or error count not cleared");

  // A frame left waiting for an ack keeps the ring non-empty
  a_wait_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.transmit && res.tx_waits_ack && !res.ack_matched
    |-> !res.queue_empty)
    else $error("waiting frame but ring reported empty");

endmodule

bind stop_and_wait_arq_sender sawarq_port_checks u_sawarq_checker (.*);

>>> tb/sv/sawarq_checker.sv
// Beat monitor, sender predictor and result scoreboard for the ARQ sender.
module sawarq_checker
  import sawarq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  logic                   cmd_ready_i,
  input  logic [IN_TDATA_W-1:0]  cmd_data_i,
  input  logic [TUSER_W-1:0]     cmd_user_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [OUT_TDATA_W-1:0] res_data_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatches_o,
  output int                     outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow config
  logic [7:0]  retry_limit_q;
  logic [15:0] timeout_q;

  // shadow sender state
  logic [2:0]  head_q;
  logic [2:0]  tail_q;
  logic [7:0]  wait_mask_q;
  logic [7:0]  slot_seq_q    [8];
  logic        slot_ack_q    [8];
  logic        slot_nowait_q [8];
  logic [7:0]  seq_ctr_q;
  logic [7:0]  retries_q;
  logic        resend_q;
  logic [15:0] ack_timer_q;
  logic [7:0]  drop_count_q;

  result_t  pending_reports [$];
  result_t  got;
  result_t  want;
  in_item_t cmd_item;
  int       mismatch_total;

  function automatic string show(result_t r);
    return $sformatf({"tx=%0b slot=%0d seq=%02h wait=%0b pwr=%0b fail=%0b ",
                      "ackm=%0b rx=%0b rej=%0b err=%0d empty=%0b"},
                     r.transmit, r.tx_slot, r.tx_sequence, r.tx_waits_ack,
                     r.full_power, r.failure, r.ack_matched, r.rx_delivered,
                     r.enqueue_rejected, r.error_count, r.queue_empty);
  endfunction

  function automatic void retire_tail();
    wait_mask_q[tail_q] = 1'b0;
    tail_q = tail_q + 3'd1;
  endfunction

  // send the oldest frame unless ring empty or carrier present
  function automatic bit launch_tail(input logic busy, inout result_t r);
    logic [2:0] t;
    t = tail_q;
    if (head_q == tail_q || busy) return 1'b0;
    if (!slot_ack_q[t]) begin
      slot_seq_q[t] = seq_ctr_q;
      seq_ctr_q     = seq_ctr_q + 8'd1;
    end
    r.transmit    = 1'b1;
    r.tx_slot     = t;
    r.tx_sequence = slot_seq_q[t];
    if (slot_nowait_q[t] || slot_ack_q[t]) begin
      r.tx_waits_ack = 1'b0;
      tail_q         = tail_q + 3'd1;
    end else begin
      r.tx_waits_ack = 1'b1;
      ack_timer_q    = timeout_q;
      wait_mask_q[t] = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic result_t step_sender(input in_item_t it);
    result_t    r;
    logic [2:0] nxt;
    r   = '0;
    nxt = head_q + 3'd1;
    case (it.action)
      ACT_ENQUEUE: begin
        if (nxt == tail_q) begin
          r.enqueue_rejected = 1'b1;
        end else begin
          wait_mask_q[head_q]   = 1'b0;
          slot_ack_q[head_q]    = it.data.frame_is_ack;
          slot_nowait_q[head_q] = it.data.frame_is_datagram | it.data.frame_is_broadcast;
          slot_seq_q[head_q]    = it.data.frame_sequence;
          head_q                = nxt;
        end
      end
      ACT_SERVICE: begin
        if (head_q != tail_q) begin
          if (!wait_mask_q[tail_q]) begin
            void'(launch_tail(it.data.channel_busy, r));
            retries_q = 8'd0;
            resend_q  = 1'b0;
          end else if (ack_timer_q == 16'd0) begin
            if (retries_q < retry_limit_q) begin
              r.full_power = 1'b1;
              resend_q     = 1'b1;
              retries_q    = retries_q + 8'd1;
            end else begin
              if (drop_count_q != 8'hFF) drop_count_q = drop_count_q + 8'd1;
              r.failure = 1'b1;
              retire_tail();
            end
          end
        end
        if (resend_q && launch_tail(it.data.channel_busy, r)) resend_q = 1'b0;
        if (it.data.rx_valid) begin
          if (wait_mask_q[tail_q] && slot_seq_q[tail_q] == it.data.rx_sequence &&
              it.data.rx_is_ack) begin
            retire_tail();
            r.ack_matched = 1'b1;
          end
          drop_count_q   = 8'd0;
          r.rx_delivered = 1'b1;
        end
      end
      ACT_TICK: begin
        if (ack_timer_q != 16'd0) ack_timer_q = ack_timer_q - 16'd1;
      end
      default: ;
    endcase
    r.error_count = drop_count_q;
    r.queue_empty = (head_q == tail_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q = RETRY_LIMIT_RST;
      timeout_q     = TIMEOUT_TICKS_RST;
      head_q        = '0;
      tail_q        = '0;
      wait_mask_q   = '0;
      seq_ctr_q     = '0;
      retries_q     = '0;
      resend_q      = 1'b0;
      ack_timer_q   = '0;
      drop_count_q  = '0;
      for (int i = 0; i < 8; i++) begin
        slot_seq_q[i]    = '0;
        slot_ack_q[i]    = 1'b0;
        slot_nowait_q[i] = 1'b0;
      end
      pending_reports.delete();
      mismatch_total = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_data_i[RES_W-1:0]);
        if (pending_reports.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("[%0t] unexpected result beat: %s", $realtime, show(got));
        end else begin
          want = pending_reports.pop_front();
          if (got !== want || res_data_i[OUT_TDATA_W-1:RES_W] !== '0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("[%0t] result mismatch\n  want: %s\n  got:  %s (fill %h)",
                       $realtime, show(want), show(got),
                       res_data_i[OUT_TDATA_W-1:RES_W]);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RETRY_LIMIT:   retry_limit_q = cfg_data_i[7:0];
          CFG_TIMEOUT_TICKS: timeout_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) begin
        cmd_item.action = act_e'(cmd_user_i);
        cmd_item.data   = cmd_data_i[IN_W-1:0];
        pending_reports.push_back(step_sender(cmd_item));
      end
      mismatches_o  <= mismatch_total;
      outstanding_o <= pending_reports.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Stimulus, clocking and verdict for the stop-and-wait ARQ sender bench.
module tb_top
  import sawarq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [TUSER_W-1:0]     s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int mismatches;
  int pending_beats;

  // idle/stall odds, percent per cycle, changed per phase
  int sender_idle_pct;
  int recv_stall_pct;

  // sequence of the latest frame sent that waits for an ack; lets the
  // stimulus answer with a matching ack most of the time
  logic [7:0] last_wait_seq;

  // coverage tallies, for the summary only
  int      beats_sent;
  int      settings_run;
  int      n_sends;
  int      n_retries;
  int      n_drops;
  int      n_ack_hits;
  int      n_rejects;
  bit      saw_saturation;
  result_t seen;

  stop_and_wait_arq_sender u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sawarq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_i   (s_axis_tready),
    .cmd_data_i    (s_axis_tdata),
    .cmd_user_i    (s_axis_tuser),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (pending_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run (~0.9k beats, 66% stalls).
  initial begin
    #2_000_000;
    $display("timeout: %0d result beats still outstanding", pending_beats);
    $display("FAIL");
    $finish;
  end

  // Result side: tready toggles at the falling edge with the phase's odds.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Snoop accepted result beats: track the waiting frame's sequence and tally
  // what kinds of results went by.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = result_t'(m_axis_tdata[RES_W-1:0]);
      if (seen.transmit && seen.tx_waits_ack) last_wait_seq <= seen.tx_sequence;
      n_sends    += seen.transmit;
      n_retries  += seen.full_power;
      n_drops    += seen.failure;
      n_ack_hits += seen.ack_matched;
      n_rejects  += seen.enqueue_rejected;
      if (seen.error_count == 8'hFF) saw_saturation = 1'b1;
    end
  end

  function automatic in_data_t mk(bit ack, bit dgram, bit bcast, logic [7:0] fseq,
                                  bit busy, bit rxv, logic [7:0] rxs, bit rxa);
    in_data_t d;
    d.frame_is_ack       = ack;
    d.frame_is_datagram  = dgram;
    d.frame_is_broadcast = bcast;
    d.frame_sequence     = fseq;
    d.channel_busy       = busy;
    d.rx_valid           = rxv;
    d.rx_sequence        = rxs;
    d.rx_is_ack          = rxa;
    return d;
  endfunction

  // Mostly well-formed traffic: enqueues, service passes that often carry
  // the right ack, timer ticks; plus NOPs and wrong/flagless acks as noise.
  function automatic void random_command(output act_e act, output in_data_t d);
    int pick;
    d    = IN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      act                  = ACT_ENQUEUE;
      d.frame_is_ack       = ($urandom_range(99) < 15);
      d.frame_is_datagram  = ($urandom_range(99) < 20);
      d.frame_is_broadcast = ($urandom_range(99) < 20);
    end else if (pick < 70) begin
      act            = ACT_SERVICE;
      d.channel_busy = ($urandom_range(99) < 20);
      d.rx_valid     = ($urandom_range(99) < 35);
      d.rx_is_ack    = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 75) d.rx_sequence = last_wait_seq;
    end else if (pick < 95) begin
      act = ACT_TICK;
    end else begin
      act = ACT_NOP;
    end
  endfunction

  // Present one command beat at the falling edge, after a random gap, and
  // hold it until the rising edge that takes it. tvalid stays high between
  // back-to-back beats.
  task automatic push_command(input act_e act, input in_data_t d);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(d);
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Stop sending, wait until every result is back, and let the two-stage pipe
  // settle before returning.
  task automatic drain_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_beats != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // New register setting on an idle block; the retry limit write carries
  // junk in its unused upper byte.
  task automatic apply_setting(input logic [7:0] limit, input logic [15:0] ticks,
                               input int s_pct, input int r_pct);
    drain_sender();
    write_reg(CFG_RETRY_LIMIT, {8'($urandom), limit});
    write_reg(CFG_TIMEOUT_TICKS, ticks);
    sender_idle_pct = s_pct;
    recv_stall_pct  = r_pct;
    settings_run++;
  endtask

  task automatic run_phase(input logic [7:0] limit, input logic [15:0] ticks,
                           input int s_pct, input int r_pct, input int n);
    act_e     act;
    in_data_t d;
    apply_setting(limit, ticks, s_pct, r_pct);
    repeat (n) begin
      random_command(act, d);
      push_command(act, d);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = ACT_NOP;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_RETRY_LIMIT;
    cfg_data_i      = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    last_wait_seq   = '0;
    beats_sent      = 0;
    settings_run    = 1;
    n_sends         = 0;
    n_retries       = 0;
    n_drops         = 0;
    n_ack_hits      = 0;
    n_rejects       = 0;
    saw_saturation  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed, reset config (3 retries, 500 ticks) ----
    // service on empty ring with a stray ack: delivered, nothing matched
    push_command(ACT_SERVICE, mk(0, 0, 0, 8'h00, 0, 1, 8'hFF, 1));
    push_command(ACT_NOP, '1);                     // NOP with all payload bits set
    push_command(ACT_TICK, '0);                    // tick with timer at zero
    push_command(ACT_ENQUEUE, mk(0, 0, 0, 8'hFF, 0, 0, 8'h00, 0));  // data frame
    push_command(ACT_SERVICE, mk(0, 0, 0, 8'h00, 1, 0, 8'h00, 0));  // carrier: held
    push_command(ACT_SERVICE, '0);                 // first send, arms timer
    drain_sender();
    // right sequence but no ack flag, then the real ack
    push_command(ACT_SERVICE, mk(0, 0, 0, 8'h00, 0, 1, last_wait_seq, 0));
    push_command(ACT_SERVICE, mk(0, 0, 0, 8'h00, 0, 1, last_wait_seq, 1));
    // fill the ring: every frame kind, then one enqueue too many
    push_command(ACT_ENQUEUE, mk(1, 0, 0, 8'hA5, 0, 0, 8'h00, 0));
    push_command(ACT_ENQUEUE, mk(0, 1, 0, 8'h00, 0, 0, 8'h00, 0));
    push_command(ACT_ENQUEUE, mk(0, 0, 1, 8'h00, 0, 0, 8'h00, 0));
    push_command(ACT_ENQUEUE, mk(1, 1, 1, 8'h5A, 0, 0, 8'h00, 0));
    repeat (3) push_command(ACT_ENQUEUE, mk(0, 0, 0, 8'($urandom), 0, 0, 8'h00, 0));
    push_command(ACT_ENQUEUE, mk(0, 0, 0, 8'h00, 0, 0, 8'h00, 0));  // ring full
    // ack, datagram, broadcast, all-flags go out without waiting; then data
    repeat (5) push_command(ACT_SERVICE, '0);
    repeat (2) push_command(ACT_TICK, '0);
    drain_sender();
    push_command(ACT_SERVICE, mk(0, 0, 0, 8'h00, 0, 1, last_wait_seq, 1));

    // ---- random phases across register extremes and idle patterns ----
    run_phase(8'd0,   16'd1,     0,  0,  20);    // no idling
    run_phase(8'd255, 16'd0,     66, 0,  20);    // zero timeout, sender gaps
    run_phase(8'd2,   16'd4,     0,  66, 20);    // receiver backpressure

    // Error counter saturation: no retries, zero timeout, never any rx, so
    // each data frame costs one send pass and one drop pass.
    apply_setting(8'd0, 16'd0, 0, 14);
    repeat (16) push_command(ACT_SERVICE, '0);   // flush leftovers
    repeat (37) begin
      repeat (7) push_command(ACT_ENQUEUE, mk(0, 0, 0, 8'($urandom), 0, 0, 8'h00, 0));
      repeat (14) push_command(ACT_SERVICE, mk(0, 0, 0, 8'h00, 0, 0, 8'($urandom), 0));
    end

    run_phase(8'd3,   16'd65535, 14, 14, 20);    // max timeout, both idle
    run_phase(8'd5,   16'd2,     14, 14, 20);

    drain_sender();
    $display("Covered %0d command beats over %0d register settings, idle/stall mixes 0-66%%.",
             beats_sent, settings_run);
    $display("Seen: %0d sends, %0d retries, %0d drops, %0d ack hits, %0d rejects, sat=%0b.",
             n_sends, n_retries, n_drops, n_ack_hits, n_rejects, saw_saturation);
    if (mismatches == 0 && pending_beats == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
